// ===== src/dmm_pkg.sv =====
// Shared widths, reset values and register indexes of the differential motor mixer.
package dmm_pkg;

  localparam int unsigned DemandW  = 17;
  localparam int unsigned DutyW    = 15;
  localparam int unsigned ShiftW   = 3;
  localparam int unsigned SmoothW  = 19;
  localparam int unsigned CfgDataW = 15;

  localparam logic [DutyW-1:0]  FullScaleRst   = 15'd25600;
  localparam logic [ShiftW-1:0] SmoothShiftRst = 3'd2;

  typedef enum logic [0:0] {
    CFG_FULL_SCALE   = 1'b0,
    CFG_SMOOTH_SHIFT = 1'b1
  } cfg_idx_e;

endpackage

// ===== src/differential_motor_mixer_top.sv =====
// Differential motor mixer: demand clamp with spill-over, smoothing and duty generation.
//
// Usage: a demand pair enters on the in_* valid/ready channel; each item yields
// one result on the out_* channel carrying forward and reverse duties for the
// left and right motor. Configuration (full scale, smoothing shift) is written
// on the cfg_* channel, which is always ready; write it only while no item is
// in flight.
// Path: an accepted item passes four register levels: input, left clamp and
// spill, right clamp and spill with the opposite-sign rule, and the
// smoothed-value registers, which also serve as the result register. The
// duties are decoded from the smoothed values on the way out.
// Throughput: one item per cycle while the receiver keeps out_ready_i high.
// Reset: both smoothed values clear to zero, full scale returns to 25600 and
// the shift to 2, and the pipeline empties.
// Stall: when the receiver holds out_ready_i low, the result holds and the
// stages behind it keep filling; in_ready_o falls once all four levels hold
// an item.
module differential_motor_mixer_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [dmm_pkg::DemandW-1:0]   left_demand_i,
  input  logic signed [dmm_pkg::DemandW-1:0]   right_demand_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [dmm_pkg::DutyW-1:0]     left_forward_duty_o,
  output logic        [dmm_pkg::DutyW-1:0]     left_reverse_duty_o,
  output logic        [dmm_pkg::DutyW-1:0]     right_forward_duty_o,
  output logic        [dmm_pkg::DutyW-1:0]     right_reverse_duty_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  dmm_pkg::cfg_idx_e                    cfg_index_i,
  input  logic        [dmm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dmm_pkg::*;

  localparam int unsigned BRightW = DemandW + 1;   // right side after the left spill
  localparam int unsigned CRightW = DutyW + 1;     // right side clamped to full scale
  localparam int unsigned WideW   = SmoothW + 1;

  function automatic logic [DutyW-1:0] sat_mag(logic signed [SmoothW-1:0] q,
                                               logic [DutyW-1:0] fs);
    logic [SmoothW-1:0] mag;
    begin
      mag = q[SmoothW-1] ? SmoothW'(-q) : SmoothW'(q);
      return (mag > SmoothW'(fs)) ? fs : mag[DutyW-1:0];
    end
  endfunction

  // Configuration registers.
  logic [DutyW-1:0]  full_scale_q;
  logic [ShiftW-1:0] smooth_shift_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q   <= FullScaleRst;
      smooth_shift_q <= SmoothShiftRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FULL_SCALE:   full_scale_q   <= cfg_data_i[DutyW-1:0];
        CFG_SMOOTH_SHIFT: smooth_shift_q <= cfg_data_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  logic a_valid_q, b_valid_q, c_valid_q, out_valid_q;
  logic a_free, b_free, c_free, out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign c_free     = !c_valid_q || out_free;
  assign b_free     = !b_valid_q || c_free;
  assign a_free     = !a_valid_q || b_free;
  assign in_ready_o = a_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_free)   a_valid_q   <= in_valid_i;
      if (b_free)   b_valid_q   <= a_valid_q;
      if (c_free)   c_valid_q   <= b_valid_q;
      if (out_free) out_valid_q <= c_valid_q;
    end
  end

  // Input registers.
  logic signed [DemandW-1:0] a_left_q, a_right_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_free) begin
      a_left_q  <= left_demand_i;
      a_right_q <= right_demand_i;
    end
  end

  // Left clamp; the excess beyond full scale moves to the right side.
  logic signed [BRightW-1:0] fs_b, a_l_ext, a_r_ext, l_over, l_under;
  logic signed [DemandW-1:0] b_left_d, b_left_q;
  logic signed [BRightW-1:0] b_right_d, b_right_q;

  always_comb begin
    fs_b    = signed'(BRightW'(full_scale_q));
    a_l_ext = BRightW'(a_left_q);
    a_r_ext = BRightW'(a_right_q);
    l_over  = a_l_ext - fs_b;
    l_under = a_l_ext + fs_b;
    if (l_over > 0) begin
      b_left_d  = DemandW'(fs_b);
      b_right_d = a_r_ext - l_over;
    end else if (l_under < 0) begin
      b_left_d  = DemandW'(-fs_b);
      b_right_d = a_r_ext - l_under;
    end else begin
      b_left_d  = a_left_q;
      b_right_d = a_r_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_free) begin
      b_left_q  <= b_left_d;
      b_right_q <= b_right_d;
    end
  end

  // Right clamp with spill into the left side, then the opposite-sign rule.
  logic signed [WideW-1:0]   fs_c, b_l_ext, b_r_ext, r_over, r_under;
  logic signed [SmoothW-1:0] l_mix, c_left_d, c_left_q;
  logic signed [CRightW-1:0] r_mix, c_right_d, c_right_q;

  always_comb begin
    fs_c    = signed'(WideW'(full_scale_q));
    b_l_ext = WideW'(b_left_q);
    b_r_ext = WideW'(b_right_q);
    r_over  = b_r_ext - fs_c;
    r_under = b_r_ext + fs_c;
    if (r_over > 0) begin
      l_mix = SmoothW'(b_l_ext - r_over);
      r_mix = CRightW'(fs_c);
    end else if (r_under < 0) begin
      l_mix = SmoothW'(b_l_ext - r_under);
      r_mix = CRightW'(-fs_c);
    end else begin
      l_mix = SmoothW'(b_l_ext);
      r_mix = CRightW'(b_r_ext);
    end
    c_left_d  = l_mix;
    c_right_d = r_mix;
    if (l_mix < 0 && r_mix > 0) begin
      c_left_d = '0;
    end
    if (l_mix > 0 && r_mix < 0) begin
      c_right_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q && c_free) begin
      c_left_q  <= c_left_d;
      c_right_q <= c_right_d;
    end
  end

  // First-order smoothing; the arithmetic shift rounds toward minus infinity.
  logic signed [SmoothW-1:0] left_smooth_q, right_smooth_q;
  logic signed [SmoothW-1:0] left_smooth_d, right_smooth_d;
  logic signed [WideW-1:0]   diff_l, diff_r, step_l, step_r;

  always_comb begin
    diff_l         = WideW'(c_left_q) - WideW'(left_smooth_q);
    diff_r         = WideW'(c_right_q) - WideW'(right_smooth_q);
    step_l         = diff_l >>> smooth_shift_q;
    step_r         = diff_r >>> smooth_shift_q;
    left_smooth_d  = SmoothW'(WideW'(left_smooth_q) + step_l);
    right_smooth_d = SmoothW'(WideW'(right_smooth_q) + step_r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_smooth_q  <= '0;
      right_smooth_q <= '0;
    end else if (c_valid_q && out_free) begin
      left_smooth_q  <= left_smooth_d;
      right_smooth_q <= right_smooth_d;
    end
  end

  // Duty decode from the held smoothed values.
  logic left_pos, right_pos;
  logic [DutyW-1:0] left_sat, right_sat;

  assign left_pos  = !left_smooth_q[SmoothW-1] && (left_smooth_q != '0);
  assign right_pos = !right_smooth_q[SmoothW-1] && (right_smooth_q != '0);
  assign left_sat  = sat_mag(left_smooth_q, full_scale_q);
  assign right_sat = sat_mag(right_smooth_q, full_scale_q);

  assign out_valid_o          = out_valid_q;
  assign left_forward_duty_o  = left_pos  ? left_sat  : '0;
  assign left_reverse_duty_o  = left_pos  ? '0 : left_sat;
  assign right_forward_duty_o = right_pos ? right_sat : '0;
  assign right_reverse_duty_o = right_pos ? '0 : right_sat;

endmodule

// ===== src/dmm_checker.sv =====
// Port-level checks of the differential motor mixer and their binding to the top level.
module dmm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [dmm_pkg::DutyW-1:0]     left_forward_duty_o,
  input logic [dmm_pkg::DutyW-1:0]     left_reverse_duty_o,
  input logic [dmm_pkg::DutyW-1:0]     right_forward_duty_o,
  input logic [dmm_pkg::DutyW-1:0]     right_reverse_duty_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its duties.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(left_forward_duty_o) && $stable(left_reverse_duty_o) &&
      $stable(right_forward_duty_o) && $stable(right_reverse_duty_o))
    else $error("result changed while stalled");

  // One motor never drives forward and reverse at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (left_forward_duty_o == '0 || left_reverse_duty_o == '0) &&
      (right_forward_duty_o == '0 || right_reverse_duty_o == '0))
    else $error("forward and reverse duty both active");

  // With the receiver ready the pipeline never backs up to the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled although the receiver is ready");

endmodule

bind differential_motor_mixer_top dmm_checker u_dmm_checker (.*);
